[src/rtrd_pkg.sv]
`default_nettype none
package rtrd_pkg;

   localparam int unsigned DataWidth   = 32;
   localparam int unsigned OffsetWidth = 6;
   localparam int unsigned LogWidth    = 5;
   localparam int unsigned CountWidth  = 31;
   localparam int unsigned CsrIdxWidth = 3;

   typedef enum logic [1:0] {
      REQ_GUEST_READ   = 2'd0,
      REQ_GUEST_WRITE  = 2'd1,
      REQ_HOST_CONSUME = 2'd2,
      REQ_HOST_PUBLISH = 2'd3
   } req_kind_type;

   typedef enum logic [2:0] {
      ST_OK          = 3'd0,
      ST_UNALIGNED   = 3'd1,
      ST_UNMAPPED    = 3'd2,
      ST_UNAVAILABLE = 3'd3,
      ST_OVERRUN     = 3'd4
   } status_type;

   typedef enum logic [3:0] {
      WORD_MAGIC      = 4'd0,
      WORD_VERSION    = 4'd1,
      WORD_STATUS     = 4'd2,
      WORD_RING_BASE  = 4'd3,
      WORD_RING_SIZE  = 4'd4,
      WORD_G2H_HEAD   = 4'd5,
      WORD_G2H_TAIL   = 4'd6,
      WORD_H2G_HEAD   = 4'd7,
      WORD_H2G_TAIL   = 4'd8,
      WORD_DOORBELL   = 4'd9,
      WORD_IRQ_STATUS = 4'd10,
      WORD_IRQ_ENABLE = 4'd11
   } word_type;

   typedef enum logic [CsrIdxWidth-1:0] {
      CSR_RING_BASE     = 3'd0,
      CSR_RING_SIZE_LOG = 3'd1,
      CSR_HOST_ATTACHED = 3'd2,
      CSR_IDENT_MAGIC   = 3'd3,
      CSR_IDENT_VERSION = 3'd4
   } csr_index_type;

   typedef struct packed {
      req_kind_type           req_type;
      logic [OffsetWidth-1:0] reg_offset;
      logic [DataWidth-1:0]   write_data;
      logic [DataWidth-1:0]   byte_count;
   } req_item_type;

   typedef struct packed {
      status_type            status_code;
      logic [DataWidth-1:0]  read_data;
      logic                  doorbell_pulse;
      logic                  irq_line;
      logic [CountWidth-1:0] host_readable;
      logic [CountWidth-1:0] host_writable;
   } rsp_item_type;

   typedef struct packed {
      logic                   write_en;
      logic [CsrIdxWidth-1:0] index;
      logic [DataWidth-1:0]   data;
   } csr_write_type;

endpackage
`default_nettype wire

[src/rtrd_req_if.sv]
`default_nettype none
interface rtrd_req_if;
   logic                            valid;
   logic                            ready;
   logic [1:0]                      req_type;
   logic [rtrd_pkg::OffsetWidth-1:0] reg_offset;
   logic [rtrd_pkg::DataWidth-1:0]   write_data;
   logic [rtrd_pkg::DataWidth-1:0]   byte_count;

   modport source (output valid, req_type, reg_offset, write_data, byte_count, input ready);
   modport sink   (input valid, req_type, reg_offset, write_data, byte_count, output ready);
endinterface
`default_nettype wire

[src/rtrd_rsp_if.sv]
`default_nettype none
interface rtrd_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [2:0]                      status_code;
   logic [rtrd_pkg::DataWidth-1:0]   read_data;
   logic                            doorbell_pulse;
   logic                            irq_line;
   logic [rtrd_pkg::CountWidth-1:0]  host_readable;
   logic [rtrd_pkg::CountWidth-1:0]  host_writable;

   modport source (output valid, status_code, read_data, doorbell_pulse, irq_line,
                   host_readable, host_writable, input ready);
   modport sink   (input valid, status_code, read_data, doorbell_pulse, irq_line,
                   host_readable, host_writable, output ready);
endinterface
`default_nettype wire

[src/rtrd_in_reg.sv]
`default_nettype none
module rtrd_in_reg (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   in_valid,
   output logic                  in_ready,
   input  rtrd_pkg::req_item_type in_item,
   input  wire                   advance,
   output logic                  item_valid,
   output rtrd_pkg::req_item_type item
);
   import rtrd_pkg::*;

   logic         valid_ff, valid_in;
   req_item_type item_ff;

   // take a new item when empty or when the held one moves on this cycle
   assign in_ready = !valid_ff || advance;

   always_comb begin
      valid_in = valid_ff;
      if (in_ready) begin
         valid_in = in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (in_valid && in_ready) begin
         item_ff <= in_item;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;
endmodule
`default_nettype wire

[src/rtrd_engine.sv]
`default_nettype none
module rtrd_engine (
   input  wire                    clock,
   input  wire                    reset,
   input  rtrd_pkg::csr_write_type csr,
   input  wire                    fire,
   input  rtrd_pkg::req_item_type  item,
   output rtrd_pkg::rsp_item_type  result,
   output logic                   chan_usable
);
   import rtrd_pkg::*;

   logic [DataWidth-1:0] base_ff, magic_ff, version_ff;
   logic [LogWidth-1:0]  size_log_ff;
   logic                 attached_ff;

   logic [DataWidth-1:0] g2h_prod_ff, g2h_prod_in, g2h_cons_ff, g2h_cons_in;
   logic [DataWidth-1:0] h2g_prod_ff, h2g_prod_in, h2g_cons_ff, h2g_cons_in;
   logic                 irq_flag_ff, irq_flag_in, irq_en_ff, irq_en_in;
   logic                 overrun_ff, overrun_in;

   logic [DataWidth-1:0] mask, ring_bytes, status_word;
   logic [DataWidth-1:0] g2h_used, h2g_used, g2h_free, h2g_free;
   logic [DataWidth-1:0] g2h_used_nx, h2g_free_nx;
   logic                 usable, placed, clear_run;
   word_type             word;
   status_type           st;
   logic [DataWidth-1:0] rd;
   logic                 bell;

   assign placed     = (size_log_ff != '0);
   assign usable     = placed && attached_ff;
   assign mask       = (DataWidth'(1) << size_log_ff) - DataWidth'(1);
   assign ring_bytes = placed ? (mask + DataWidth'(1)) : '0;
   assign g2h_used   = (g2h_prod_ff - g2h_cons_ff) & mask;
   assign h2g_used   = (h2g_prod_ff - h2g_cons_ff) & mask;
   assign g2h_free   = mask - g2h_used;
   assign h2g_free   = mask - h2g_used;
   assign word       = word_type'(item.reg_offset[OffsetWidth-1:2]);

   always_comb begin
      status_word    = '0;
      status_word[0] = usable;
      status_word[1] = placed && (g2h_free == '0);
      status_word[2] = placed && (h2g_used == '0);
      status_word[3] = placed && overrun_ff;
   end

   always_comb begin
      g2h_prod_in = g2h_prod_ff;
      g2h_cons_in = g2h_cons_ff;
      h2g_prod_in = h2g_prod_ff;
      h2g_cons_in = h2g_cons_ff;
      irq_flag_in = irq_flag_ff;
      irq_en_in   = irq_en_ff;
      overrun_in  = overrun_ff;
      st          = ST_OK;
      rd          = '0;
      bell        = 1'b0;
      if (item.req_type == REQ_GUEST_READ || item.req_type == REQ_GUEST_WRITE) begin
         if (item.reg_offset[1:0] != 2'b00) begin
            st = ST_UNALIGNED;
         end else if (word > WORD_IRQ_ENABLE) begin
            st = ST_UNMAPPED;
         end else if (item.req_type == REQ_GUEST_READ) begin
            case (word)
               WORD_MAGIC:      rd = magic_ff;
               WORD_VERSION:    rd = version_ff;
               WORD_STATUS:     rd = status_word;
               WORD_RING_BASE:  rd = base_ff;
               WORD_RING_SIZE:  rd = ring_bytes;
               WORD_G2H_HEAD:   rd = g2h_prod_ff;
               WORD_G2H_TAIL:   rd = g2h_cons_ff;
               WORD_H2G_HEAD:   rd = h2g_prod_ff;
               WORD_H2G_TAIL:   rd = h2g_cons_ff;
               WORD_IRQ_STATUS: rd = DataWidth'(irq_flag_ff);
               WORD_IRQ_ENABLE: rd = DataWidth'(irq_en_ff);
               default:         rd = '0;
            endcase
         end else begin
            case (word)
               WORD_G2H_HEAD:   g2h_prod_in = item.write_data;
               WORD_H2G_TAIL:   h2g_cons_in = item.write_data;
               WORD_DOORBELL:   bell = attached_ff;
               WORD_IRQ_STATUS: begin
                  if (item.write_data[0]) begin
                     irq_flag_in = 1'b0;
                  end
               end
               WORD_IRQ_ENABLE: irq_en_in = item.write_data[0];
               default: ;
            endcase
         end
      end else if (!usable) begin
         st = ST_UNAVAILABLE;
      end else if (item.req_type == REQ_HOST_CONSUME) begin
         if (item.byte_count > g2h_used) begin
            overrun_in = 1'b1;
            st         = ST_OVERRUN;
         end else begin
            g2h_cons_in = (g2h_cons_ff + item.byte_count) & mask;
         end
      end else begin
         if (item.byte_count > h2g_free) begin
            overrun_in = 1'b1;
            st         = ST_OVERRUN;
         end else if (item.byte_count != '0) begin
            h2g_prod_in = (h2g_prod_ff + item.byte_count) & mask;
            irq_flag_in = 1'b1;
         end
      end
   end

   // levels reported with the result reflect the state after this item
   assign g2h_used_nx = (g2h_prod_in - g2h_cons_in) & mask;
   assign h2g_free_nx = mask - ((h2g_prod_in - h2g_cons_in) & mask);

   always_comb begin
      result.status_code    = st;
      result.read_data      = rd;
      result.doorbell_pulse = bell;
      result.irq_line       = usable && irq_flag_in && irq_en_in;
      result.host_readable  = usable ? g2h_used_nx[CountWidth-1:0] : '0;
      result.host_writable  = usable ? h2g_free_nx[CountWidth-1:0] : '0;
   end

   assign chan_usable = usable;
   assign clear_run   = csr.write_en && (csr.index == CSR_RING_BASE ||
                                         csr.index == CSR_RING_SIZE_LOG);

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff     <= '0;
         size_log_ff <= '0;
         attached_ff <= 1'b0;
         magic_ff    <= '0;
         version_ff  <= '0;
      end else if (csr.write_en) begin
         case (csr_index_type'(csr.index))
            CSR_RING_BASE:     base_ff     <= csr.data;
            CSR_RING_SIZE_LOG: size_log_ff <= csr.data[LogWidth-1:0];
            CSR_HOST_ATTACHED: attached_ff <= csr.data[0];
            CSR_IDENT_MAGIC:   magic_ff    <= csr.data;
            CSR_IDENT_VERSION: version_ff  <= csr.data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset || clear_run) begin
         g2h_prod_ff <= '0;
         g2h_cons_ff <= '0;
         h2g_prod_ff <= '0;
         h2g_cons_ff <= '0;
         irq_flag_ff <= 1'b0;
         irq_en_ff   <= 1'b0;
         overrun_ff  <= 1'b0;
      end else if (fire) begin
         g2h_prod_ff <= g2h_prod_in;
         g2h_cons_ff <= g2h_cons_in;
         h2g_prod_ff <= h2g_prod_in;
         h2g_cons_ff <= h2g_cons_in;
         irq_flag_ff <= irq_flag_in;
         irq_en_ff   <= irq_en_in;
         overrun_ff  <= overrun_in;
      end
   end
endmodule
`default_nettype wire

[src/ring_transport_register_device_core.sv]
`default_nettype none
// Register front end of a two-ring guest/host channel.
// req_chan carries one item per guest word read or write, or per host
// consume/publish count; rsp_chan returns exactly one result item per
// request, in order. csr_* writes the placement, attach and ident
// registers; write them only while no item is in flight. Writing the ring
// base or ring size clears the ring pointers, the interrupt bits and the
// overrun latch.
// An accepted item is held in the input register and decoded there; the
// edge that moves it into the result register also applies it to the
// ring state and raises rsp_chan.valid.
// Throughput: one item per cycle while rsp_chan is not stalled, set by
// the single decode/update pass between the input register and the
// result register.
// Reset (synchronous, active high) empties both registers and clears all
// configuration and ring state to zero.
// When rsp_chan stalls, the result register holds its item and the input
// register holds one more; req_chan.ready drops only when both are full.
module ring_transport_register_device_core (
   input  wire                                   clock,
   input  wire                                   reset,
   rtrd_req_if.sink                              req_chan,
   rtrd_rsp_if.source                            rsp_chan,
   input  wire                                   csr_write_en,
   input  wire [rtrd_pkg::CsrIdxWidth-1:0]       csr_index,
   input  wire [rtrd_pkg::DataWidth-1:0]         csr_write_data
);
   import rtrd_pkg::*;

   req_item_type  in_item, item;
   rsp_item_type  result, rsp_ff;
   csr_write_type csr;
   logic          item_valid, advance, in_ready, chan_usable;
   logic          rsp_valid_ff, rsp_valid_in;

   // pack the channel fields
   always_comb begin
      in_item.req_type   = req_kind_type'(req_chan.req_type);
      in_item.reg_offset = req_chan.reg_offset;
      in_item.write_data = req_chan.write_data;
      in_item.byte_count = req_chan.byte_count;
   end

   assign csr.write_en = csr_write_en;
   assign csr.index    = csr_index;
   assign csr.data     = csr_write_data;

   // move the held item into the result register when that register is
   // empty or its item is being taken this cycle
   assign advance        = item_valid && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = in_ready;

   rtrd_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_chan.valid),
      .in_ready   (in_ready),
      .in_item    (in_item),
      .advance    (advance),
      .item_valid (item_valid),
      .item       (item)
   );

   rtrd_engine u_engine (
      .clock       (clock),
      .reset       (reset),
      .csr         (csr),
      .fire        (advance),
      .item        (item),
      .result      (result),
      .chan_usable (chan_usable)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // hold the result until the receiver takes it
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (advance) begin
         rsp_ff <= result;
      end
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.status_code    = rsp_ff.status_code;
   assign rsp_chan.read_data      = rsp_ff.read_data;
   assign rsp_chan.doorbell_pulse = rsp_ff.doorbell_pulse;
   assign rsp_chan.irq_line       = rsp_ff.irq_line;
   assign rsp_chan.host_readable  = rsp_ff.host_readable;
   assign rsp_chan.host_writable  = rsp_ff.host_writable;

`ifndef SYNTHESIS
   a_advance_shows_result: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_chan.valid)
      else $error("item advanced but no result followed");

   a_error_has_no_data: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.status_code != ST_OK)
         |-> (rsp_chan.read_data == '0 && !rsp_chan.doorbell_pulse))
      else $error("failed request returned data or rang the doorbell");

   a_host_unavailable: assert property (@(posedge clock) disable iff (reset)
      (advance && !chan_usable &&
       (item.req_type == REQ_HOST_CONSUME || item.req_type == REQ_HOST_PUBLISH))
         |=> (rsp_chan.status_code == ST_UNAVAILABLE))
      else $error("host request on unusable channel not flagged");
`endif
endmodule
`default_nettype wire

[tb/rtrd_channel_checker.sv]
// Watches both channels and the register port, mirrors the ring state and
// compares every returned item with the oldest predicted one.
module rtrd_channel_checker (
   input  logic                             clock,
   input  logic                             reset,
   rtrd_req_if                              req_mon,
   rtrd_rsp_if                              rsp_mon,
   input  logic                             csr_write_en,
   input  logic [rtrd_pkg::CsrIdxWidth-1:0] csr_index,
   input  logic [rtrd_pkg::DataWidth-1:0]   csr_write_data,
   output int                               mismatches,
   output int                               in_flight,
   output int                               checked,
   output int                               overruns,
   output int                               bells
);
   import rtrd_pkg::*;

   localparam int MaxPrinted = 40;

   // register copies
   logic [31:0] base_q, magic_q, version_q;
   logic [4:0]  size_log2_q;
   logic        attached_q;

   // ring state
   logic [31:0] g2h_prod_q, g2h_cons_q, h2g_prod_q, h2g_cons_q;
   logic        irq_pending, irq_enabled, overrun_seen;

   rsp_item_type pending_responses[$];

   function automatic logic [31:0] ring_mask_now();
      return (size_log2_q == 5'd0) ? 32'd0 : ((32'd1 << size_log2_q) - 32'd1);
   endfunction

   function automatic logic [31:0] ring_level(logic [31:0] head, logic [31:0] tail);
      return (head - tail) & ring_mask_now();
   endfunction

   function automatic logic channel_up();
      return (size_log2_q != 5'd0) && attached_q;
   endfunction

   function automatic logic [31:0] status_bits();
      logic [31:0] s;
      s    = 32'd0;
      s[0] = channel_up();
      if (size_log2_q != 5'd0) begin
         s[1] = (ring_mask_now() - ring_level(g2h_prod_q, g2h_cons_q)) == 32'd0;
         s[2] = ring_level(h2g_prod_q, h2g_cons_q) == 32'd0;
         s[3] = overrun_seen;
      end
      return s;
   endfunction

   function automatic void clear_run_state();
      g2h_prod_q   = 32'd0;
      g2h_cons_q   = 32'd0;
      h2g_prod_q   = 32'd0;
      h2g_cons_q   = 32'd0;
      irq_pending  = 1'b0;
      irq_enabled  = 1'b0;
      overrun_seen = 1'b0;
   endfunction

   function automatic rsp_item_type apply_request(req_item_type it);
      rsp_item_type r;
      logic [3:0]   widx;
      logic [31:0]  room;
      r             = '0;
      r.status_code = ST_OK;
      widx          = it.reg_offset[5:2];
      if (it.req_type == REQ_GUEST_READ || it.req_type == REQ_GUEST_WRITE) begin
         if (it.reg_offset[1:0] != 2'b00) begin
            r.status_code = ST_UNALIGNED;
         end else if (widx > WORD_IRQ_ENABLE) begin
            r.status_code = ST_UNMAPPED;
         end else if (it.req_type == REQ_GUEST_READ) begin
            case (widx)
               WORD_MAGIC:      r.read_data = magic_q;
               WORD_VERSION:    r.read_data = version_q;
               WORD_STATUS:     r.read_data = status_bits();
               WORD_RING_BASE:  r.read_data = base_q;
               WORD_RING_SIZE:  r.read_data = (size_log2_q == 5'd0) ? 32'd0
                                                                  : (32'd1 << size_log2_q);
               WORD_G2H_HEAD:   r.read_data = g2h_prod_q;
               WORD_G2H_TAIL:   r.read_data = g2h_cons_q;
               WORD_H2G_HEAD:   r.read_data = h2g_prod_q;
               WORD_H2G_TAIL:   r.read_data = h2g_cons_q;
               WORD_IRQ_STATUS: r.read_data = {31'd0, irq_pending};
               WORD_IRQ_ENABLE: r.read_data = {31'd0, irq_enabled};
               default:         r.read_data = 32'd0;
            endcase
         end else begin
            case (widx)
               WORD_G2H_HEAD:   g2h_prod_q = it.write_data;
               WORD_H2G_TAIL:   h2g_cons_q = it.write_data;
               WORD_DOORBELL:   r.doorbell_pulse = attached_q;
               WORD_IRQ_STATUS: if (it.write_data[0]) irq_pending = 1'b0;
               WORD_IRQ_ENABLE: irq_enabled = it.write_data[0];
               default: ;
            endcase
         end
      end else if (!channel_up()) begin
         r.status_code = ST_UNAVAILABLE;
      end else if (it.req_type == REQ_HOST_CONSUME) begin
         if (it.byte_count > ring_level(g2h_prod_q, g2h_cons_q)) begin
            overrun_seen  = 1'b1;
            r.status_code = ST_OVERRUN;
         end else begin
            g2h_cons_q = (g2h_cons_q + it.byte_count) & ring_mask_now();
         end
      end else begin
         room = ring_mask_now() - ring_level(h2g_prod_q, h2g_cons_q);
         if (it.byte_count > room) begin
            overrun_seen  = 1'b1;
            r.status_code = ST_OVERRUN;
         end else if (it.byte_count != 32'd0) begin
            h2g_prod_q  = (h2g_prod_q + it.byte_count) & ring_mask_now();
            irq_pending = 1'b1;
         end
      end
      r.irq_line = channel_up() && irq_pending && irq_enabled;
      if (channel_up()) begin
         r.host_readable = 31'(ring_level(g2h_prod_q, g2h_cons_q));
         r.host_writable = 31'(ring_mask_now() - ring_level(h2g_prod_q, h2g_cons_q));
      end
      return r;
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      if (mismatches < MaxPrinted)
         $display("%0t: mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
      mismatches++;
   endtask

   always @(posedge clock) begin
      req_item_type req_now;
      rsp_item_type got;
      rsp_item_type want;
      if (reset) begin
         base_q      = 32'd0;
         magic_q     = 32'd0;
         version_q   = 32'd0;
         size_log2_q = 5'd0;
         attached_q  = 1'b0;
         clear_run_state();
         pending_responses.delete();
      end else begin
         if (csr_write_en) begin
            case (csr_index_type'(csr_index))
               CSR_RING_BASE: begin
                  base_q = csr_write_data;
                  clear_run_state();
               end
               CSR_RING_SIZE_LOG: begin
                  size_log2_q = csr_write_data[4:0];
                  clear_run_state();
               end
               CSR_HOST_ATTACHED: attached_q = csr_write_data[0];
               CSR_IDENT_MAGIC:   magic_q    = csr_write_data;
               CSR_IDENT_VERSION: version_q  = csr_write_data;
               default: ;
            endcase
         end
         // match the returned item before predicting a new one
         if (rsp_mon.valid && rsp_mon.ready) begin
            got.status_code    = status_type'(rsp_mon.status_code);
            got.read_data      = rsp_mon.read_data;
            got.doorbell_pulse = rsp_mon.doorbell_pulse;
            got.irq_line       = rsp_mon.irq_line;
            got.host_readable  = rsp_mon.host_readable;
            got.host_writable  = rsp_mon.host_writable;
            if (pending_responses.size() == 0) begin
               report_mismatch("unexpected item", 32'(got.status_code), 32'd0);
            end else begin
               want = pending_responses.pop_front();
               checked++;
               if (got.status_code !== want.status_code)
                  report_mismatch("status_code", 32'(got.status_code), 32'(want.status_code));
               if (got.read_data !== want.read_data)
                  report_mismatch("read_data", got.read_data, want.read_data);
               if (got.doorbell_pulse !== want.doorbell_pulse)
                  report_mismatch("doorbell_pulse", 32'(got.doorbell_pulse),
                                  32'(want.doorbell_pulse));
               if (got.irq_line !== want.irq_line)
                  report_mismatch("irq_line", 32'(got.irq_line), 32'(want.irq_line));
               if (got.host_readable !== want.host_readable)
                  report_mismatch("host_readable", 32'(got.host_readable),
                                  32'(want.host_readable));
               if (got.host_writable !== want.host_writable)
                  report_mismatch("host_writable", 32'(got.host_writable),
                                  32'(want.host_writable));
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            req_now.req_type   = req_kind_type'(req_mon.req_type);
            req_now.reg_offset = req_mon.reg_offset;
            req_now.write_data = req_mon.write_data;
            req_now.byte_count = req_mon.byte_count;
            want = apply_request(req_now);
            if (want.status_code == ST_OVERRUN) overruns++;
            if (want.doorbell_pulse) bells++;
            pending_responses.push_back(want);
         end
      end
      in_flight <= pending_responses.size();
   end

endmodule

[tb/tb_ring_transport_register_device_core.sv]
// Stimulus and verdict for the ring transport register block. The checker
// beside the block does all prediction; this module only makes traffic.
module tb_ring_transport_register_device_core;
   import rtrd_pkg::*;

   localparam int          QuietLimit   = 2000;
   localparam int          ItemsPerRing = 60;
   // ring sizes visited by the random part, extremes included
   localparam int unsigned RingPlan [9] = '{1, 31, 2, 4, 0, 3, 5, 17, 2};

   logic                   clock;
   logic                   reset;
   logic                   csr_write_en;
   logic [CsrIdxWidth-1:0] csr_index;
   logic [DataWidth-1:0]   csr_write_data;

   rtrd_req_if req_chan ();
   rtrd_rsp_if rsp_chan ();

   int          mismatches, in_flight, checked, overruns, bells;
   int unsigned send_idle_pct, recv_stall_pct;
   int unsigned ring_log2_now;
   int          settings_done;
   int          quiet_cycles;

   ring_transport_register_device_core dut (
      .clock          (clock),
      .reset          (reset),
      .req_chan       (req_chan),
      .rsp_chan       (rsp_chan),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data)
   );

   rtrd_channel_checker checker_i (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_chan),
      .rsp_mon        (rsp_chan),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data),
      .mismatches     (mismatches),
      .in_flight      (in_flight),
      .checked        (checked),
      .overruns       (overruns),
      .bells          (bells)
   );

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   // Result side: stall at random at the current rate.
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Watchdog: end the run if nothing moves on either channel for too long.
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QuietLimit) begin
         $display("watchdog: no item moved for %0d cycles, %0d still expected",
                  quiet_cycles, in_flight);
         $display("TEST FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic req_item_type request(req_kind_type kind, logic [5:0] offset,
                                            logic [31:0] data, logic [31:0] count);
      req_item_type it;
      it.req_type   = kind;
      it.reg_offset = offset;
      it.write_data = data;
      it.byte_count = count;
      return it;
   endfunction

   // Build one random item. Just over half are host ring traffic sized to the
   // current ring so that full, empty and overrun all come up, most of the rest
   // are aligned guest word accesses, and the remainder is noise across every field.
   function automatic req_item_type random_request();
      req_item_type it;
      logic [31:0]  span, mask, cap;
      int unsigned  pick;
      logic [3:0]   widx;
      span = (ring_log2_now == 0) ? 32'd0 : (32'd1 << ring_log2_now);
      mask = (span == 32'd0) ? 32'd0 : span - 32'd1;
      cap  = (span > 32'd64) ? 32'd64 : span;
      pick = $urandom_range(99);
      it   = request(req_kind_type'($urandom_range(3)), 6'($urandom_range(63)),
                     $urandom, $urandom);
      if (pick < 28 || (pick >= 52 && pick < 52)) begin
         it.req_type = REQ_HOST_CONSUME;
      end else if (pick < 52) begin
         it.req_type = REQ_HOST_PUBLISH;
      end
      if (pick < 52) begin
         if ($urandom_range(4) != 0) it.byte_count = $urandom_range(cap);
      end else if (pick < 92) begin
         it.req_type = ($urandom_range(1) == 0) ? REQ_GUEST_READ : REQ_GUEST_WRITE;
         // lean on the pointer, doorbell and interrupt words
         if ($urandom_range(1) == 0) begin
            case ($urandom_range(4))
               0:       widx = WORD_G2H_HEAD;
               1:       widx = WORD_H2G_TAIL;
               2:       widx = WORD_DOORBELL;
               3:       widx = WORD_IRQ_STATUS;
               default: widx = WORD_IRQ_ENABLE;
            endcase
         end else begin
            widx = 4'($urandom_range(11));
         end
         it.reg_offset = {widx, 2'b00};
         // raw pointer values: small in-ring values with random upper bits
         if ((widx == WORD_G2H_HEAD || widx == WORD_H2G_TAIL) && $urandom_range(3) != 0)
            it.write_data = ($urandom & ~mask) | $urandom_range(cap);
      end
      return it;
   endfunction

   // Hold an item on the request channel until it is taken, after an
   // optional random gap.
   task automatic send_request(req_item_type it);
      if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_chan.valid      <= 1'b1;
      req_chan.req_type   <= it.req_type;
      req_chan.reg_offset <= it.reg_offset;
      req_chan.write_data <= it.write_data;
      req_chan.byte_count <= it.byte_count;
      do @(posedge clock); while (!req_chan.ready);
   endtask

   // Drop valid and wait for every predicted item to come back.
   task automatic wait_drained();
      req_chan.valid <= 1'b0;
      do @(posedge clock); while (in_flight != 0);
   endtask

   // Write one register, only with the block idle.
   task automatic configure(csr_index_type idx, logic [31:0] value);
      wait_drained();
      repeat (3) @(posedge clock);
      csr_write_en   <= 1'b1;
      csr_index      <= idx;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_en   <= 1'b0;
      if (idx == CSR_RING_SIZE_LOG) ring_log2_now = value[4:0];
      settings_done++;
   endtask

   initial begin
      reset               = 1'b1;
      csr_write_en        = 1'b0;
      csr_index           = '0;
      csr_write_data      = '0;
      req_chan.valid      = 1'b0;
      req_chan.req_type   = '0;
      req_chan.reg_offset = '0;
      req_chan.write_data = '0;
      req_chan.byte_count = '0;
      send_idle_pct       = 27;
      recv_stall_pct      = 72;
      ring_log2_now       = 0;
      settings_done       = 0;

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Straight out of reset: no ring, no host, identification all zero.
      send_request(request(REQ_GUEST_READ, {WORD_MAGIC, 2'b00}, 32'd0, 32'd0));
      send_request(request(REQ_GUEST_READ, {WORD_STATUS, 2'b00}, 32'd0, 32'd0));
      send_request(request(REQ_GUEST_READ, {WORD_RING_SIZE, 2'b00}, 32'd0, 32'd0));
      send_request(request(REQ_HOST_CONSUME, 6'd0, 32'd0, 32'd0));
      send_request(request(REQ_HOST_PUBLISH, 6'd63, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
      send_request(request(REQ_GUEST_WRITE, {WORD_DOORBELL, 2'b00}, 32'hFFFF_FFFF, 32'd0));
      send_request(request(REQ_GUEST_READ, 6'd63, 32'd0, 32'd0));
      send_request(request(REQ_GUEST_WRITE, 6'd48, 32'hFFFF_FFFF, 32'd0));

      // Place an 8-byte ring with no host attached yet.
      configure(CSR_RING_BASE, 32'hFFFF_FFFC);
      configure(CSR_RING_SIZE_LOG, 32'd3);
      configure(CSR_IDENT_MAGIC, 32'hFFFF_FFFF);
      configure(CSR_IDENT_VERSION, 32'd0);
      configure(CSR_HOST_ATTACHED, 32'd0);
      send_request(request(REQ_GUEST_READ, {WORD_STATUS, 2'b00}, 32'd0, 32'd0));
      // raw head with high bits set leaves seven bytes used: ring full
      send_request(request(REQ_GUEST_WRITE, {WORD_G2H_HEAD, 2'b00}, 32'hFFFF_FFF7, 32'd0));
      send_request(request(REQ_GUEST_READ, {WORD_STATUS, 2'b00}, 32'd0, 32'd0));
      send_request(request(REQ_HOST_CONSUME, 6'd0, 32'd0, 32'd1));

      // Attach the host and walk both rings through full, empty and overrun.
      configure(CSR_HOST_ATTACHED, 32'd1);
      send_request(request(REQ_GUEST_READ, {WORD_G2H_HEAD, 2'b00}, 32'd0, 32'd0));
      send_request(request(REQ_HOST_CONSUME, 6'd0, 32'd0, 32'd8));
      send_request(request(REQ_HOST_CONSUME, 6'd0, 32'd0, 32'd7));
      send_request(request(REQ_HOST_PUBLISH, 6'd0, 32'd0, 32'd0));
      send_request(request(REQ_GUEST_WRITE, {WORD_IRQ_ENABLE, 2'b00}, 32'hFFFF_FFFF, 32'd0));
      send_request(request(REQ_HOST_PUBLISH, 6'd0, 32'd0, 32'd7));
      send_request(request(REQ_HOST_PUBLISH, 6'd0, 32'd0, 32'd1));
      send_request(request(REQ_GUEST_WRITE, {WORD_IRQ_STATUS, 2'b00}, 32'hFFFF_FFFE, 32'd0));
      send_request(request(REQ_GUEST_WRITE, {WORD_IRQ_STATUS, 2'b00}, 32'd1, 32'd0));
      send_request(request(REQ_GUEST_WRITE, {WORD_DOORBELL, 2'b00}, 32'd0, 32'd0));
      send_request(request(REQ_GUEST_READ, {WORD_DOORBELL, 2'b00}, 32'd0, 32'd0));
      send_request(request(REQ_GUEST_WRITE, {WORD_MAGIC, 2'b00}, 32'd0, 32'd0));
      send_request(request(REQ_GUEST_WRITE, {WORD_H2G_TAIL, 2'b00}, 32'hFFFF_FFFF, 32'd0));
      send_request(request(REQ_GUEST_READ, {WORD_STATUS, 2'b00}, 32'd0, 32'd0));

      // Random part: one ring placement per segment; idling modes advance
      // every three segments (sender light, then receiver light, then none).
      for (int seg = 0; seg < 9; seg++) begin
         case (seg / 3)
            0: begin
               send_idle_pct  = 27;
               recv_stall_pct = 72;
            end
            1: begin
               send_idle_pct  = 72;
               recv_stall_pct = 27;
            end
            default: begin
               send_idle_pct  = 0;
               recv_stall_pct = 0;
            end
         endcase
         configure(CSR_RING_BASE, (seg == 0) ? 32'd0 : (seg == 1) ? 32'hFFFF_FFFF : $urandom);
         configure(CSR_RING_SIZE_LOG, RingPlan[seg]);
         configure(CSR_HOST_ATTACHED, ($urandom_range(7) != 0) ? 32'd1 : 32'd0);
         configure(CSR_IDENT_MAGIC, $urandom);
         configure(CSR_IDENT_VERSION, (seg == 8) ? 32'hFFFF_FFFF : $urandom);
         for (int n = 0; n < ItemsPerRing; n++) begin
            // hold off mid-segment until the block has answered everything
            if (n == ItemsPerRing / 2 && seg % 3 == 1) wait_drained();
            send_request(random_request());
         end
      end

      wait_drained();
      repeat (4) @(posedge clock);

      $display("Summary: %0d items checked over %0d register writes, ring sizes 2 to 2^31",
               checked, settings_done);
      $display("Summary: %0d overruns, %0d doorbells, %0d mismatches",
               overruns, bells, mismatches);
      if (mismatches == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

[sim.f]
src/rtrd_pkg.sv
src/rtrd_req_if.sv
src/rtrd_rsp_if.sv
src/rtrd_in_reg.sv
src/rtrd_engine.sv
src/ring_transport_register_device_core.sv
tb/rtrd_channel_checker.sv
tb/tb_ring_transport_register_device_core.sv
